### rtl/rtsd_pkg.sv
// ----------------------------------------------------------------------------
// rtsd_pkg
// Shared codes and controller/datapath interface types for the record table.
// ----------------------------------------------------------------------------
package rtsd_pkg;

    // action codes (s_tuser)
    localparam logic [2:0] ACT_ADD       = 3'd0;
    localparam logic [2:0] ACT_DEL_NAME  = 3'd1;
    localparam logic [2:0] ACT_DEL_YEAR  = 3'd2;
    localparam logic [2:0] ACT_DEL_SEX   = 3'd3;
    localparam logic [2:0] ACT_LIST_NAME = 3'd4;
    localparam logic [2:0] ACT_LIST_YEAR = 3'd5;

    // result status codes (m_tuser)
    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_REC   = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_F = 8'h46;

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;
    localparam logic [6:0] CAPACITY_RST  = 7'd64;

    typedef struct packed {
        logic       capture;
        logic       add_wr;
        logic       scan_start;
        logic       rd_issue;
        logic       emit;
        logic [2:0] emit_status;
        logic       del_commit;
        logic       list_step;
    } rtsd_cmd_t;

    typedef struct packed {
        logic add_ok;
        logic count_zero;
        logic rd_done;
        logic out_free;
        logic list_last;
    } rtsd_stat_t;

endpackage

### rtl/rtsd_ctrl.sv
// ----------------------------------------------------------------------------
// rtsd_ctrl
// Sequencer: decodes the action and steps the datapath through scans.
// ----------------------------------------------------------------------------
module rtsd_ctrl import rtsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [2:0] s_tuser,
    output logic       s_tready,
    input  rtsd_stat_t stat,
    output rtsd_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD    = 4'd1;
    localparam logic [3:0] S_DSCAN  = 4'd2;
    localparam logic [3:0] S_DDRAIN = 4'd3;
    localparam logic [3:0] S_DEND   = 4'd4;
    localparam logic [3:0] S_LSCAN  = 4'd5;
    localparam logic [3:0] S_LDRAIN = 4'd6;
    localparam logic [3:0] S_LEMIT  = 4'd7;
    localparam logic [3:0] S_EMPTY  = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (s_tuser) inside
                        ACT_ADD: state_next = S_ADD;
                        ACT_DEL_NAME, ACT_DEL_YEAR, ACT_DEL_SEX: begin
                            if (stat.count_zero) begin
                                state_next = S_DEND;
                            end else begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_DSCAN;
                            end
                        end
                        ACT_LIST_NAME, ACT_LIST_YEAR: begin
                            if (stat.count_zero) begin
                                state_next = S_EMPTY;
                            end else begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_LSCAN;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = stat.add_ok ? ST_ADDED : ST_FULL;
                    cmd.add_wr      = stat.add_ok;
                    state_next      = S_IDLE;
                end
            end
            S_DSCAN: begin
                cmd.rd_issue = 1'b1;
                if (stat.rd_done) state_next = S_DDRAIN;
            end
            S_DDRAIN: state_next = S_DEND;
            S_DEND: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_COUNT;
                    cmd.del_commit  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LSCAN: begin
                cmd.rd_issue = 1'b1;
                if (stat.rd_done) state_next = S_LDRAIN;
            end
            S_LDRAIN: state_next = S_LEMIT;
            S_LEMIT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_REC;
                    cmd.list_step   = 1'b1;
                    if (stat.list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_LSCAN;
                    end
                end
            end
            S_EMPTY: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_EMPTY;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/rtsd_dp.sv
// ----------------------------------------------------------------------------
// rtsd_dp
// Record memory, scan counters, match/compare logic and output register.
// ----------------------------------------------------------------------------
module rtsd_dp import rtsd_pkg::*; #(
    parameter int MAX_RECORDS = 64,
    parameter int NAME_BITS   = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           in_action,
    input  logic [NAME_BITS-1:0] in_name,
    input  logic [15:0]          in_year,
    input  logic [7:0]           in_sex,
    input  logic [6:0]           capacity,
    input  rtsd_cmd_t            cmd,
    output rtsd_stat_t           stat,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [87:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int KW = (NAME_BITS > 15) ? NAME_BITS : 15;
    localparam int RW = NAME_BITS + 16;

    logic [RW-1:0] mem [MAX_RECORDS];

    logic [2:0]           act_reg;
    logic [NAME_BITS-1:0] key_reg;
    logic [15:0]          year_reg;
    logic [7:0]           sex_reg;

    logic [CW-1:0] count_reg, kept_reg, removed_reg, k_reg;
    logic [AW-1:0] j_reg, rdi_reg, prev_idx_reg, best_idx_reg;
    logic          rdv_reg, first_reg, found_reg;
    logic [RW-1:0] rd_data_reg, best_reg;
    logic [KW-1:0] prev_key_reg, best_key_reg;

    logic          out_valid_reg, out_last_reg, out_male_reg;
    logic [2:0]    out_status_reg;
    logic [6:0]    out_removed_reg;
    logic [63:0]   out_name_reg;
    logic [14:0]   out_year_reg;

    // record fields of the word just read
    logic [NAME_BITS-1:0] rd_name;
    logic [14:0]          rd_year;
    logic                 rd_male;
    logic                 match, above, better;
    logic [KW-1:0]        rd_key;
    logic                 by_year;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [RW-1:0]        wr_data;
    logic                 is_list;
    logic [NAME_BITS-1:0] in_name_l;
    logic [14:0]          in_year_l;

    assign rd_name = rd_data_reg[RW-1:16];
    assign rd_year = rd_data_reg[15:1];
    assign rd_male = rd_data_reg[0];
    assign by_year = (act_reg == ACT_LIST_YEAR);
    assign is_list = (act_reg == ACT_LIST_NAME) || (act_reg == ACT_LIST_YEAR);
    assign rd_key  = by_year ? KW'(rd_year) : KW'(rd_name);

    always_comb begin
        case (act_reg)
            ACT_DEL_NAME: match = (rd_name == key_reg);
            ACT_DEL_YEAR: match = !year_reg[15] && (rd_year == year_reg[14:0]);
            ACT_DEL_SEX:  match = (sex_reg == CHAR_M) ? rd_male :
                                  (sex_reg == CHAR_F) ? !rd_male : 1'b0;
            default:      match = 1'b0;
        endcase
    end

    // next record in (key, index) order after the previous one emitted
    assign above  = first_reg || (rd_key > prev_key_reg) ||
                    ((rd_key == prev_key_reg) && (rdi_reg > prev_idx_reg));
    assign better = !found_reg || (rd_key < best_key_reg);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = kept_reg[AW-1:0];
        wr_data = rd_data_reg;
        if (cmd.add_wr) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = {in_name_l, in_year_l, (sex_reg == CHAR_M)};
        end else if (rdv_reg && !is_list && !match) begin
            wr_en = 1'b1;
        end
    end

    assign in_name_l = key_reg;
    assign in_year_l = year_reg[15] ? 15'd0 : year_reg[14:0];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_issue) rd_data_reg <= mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= in_action;
            key_reg  <= in_name;
            year_reg <= in_year;
            sex_reg  <= in_sex;
        end
        rdi_reg <= j_reg;
        if (rdv_reg && is_list && above && better) begin
            best_reg     <= rd_data_reg;
            best_key_reg <= rd_key;
            best_idx_reg <= rdi_reg;
        end
        if (cmd.list_step) begin
            prev_key_reg <= best_key_reg;
            prev_idx_reg <= best_idx_reg;
        end
        if (cmd.emit) begin
            out_status_reg  <= cmd.emit_status;
            out_removed_reg <= (cmd.emit_status == ST_COUNT) ? 7'(removed_reg) : 7'd0;
            out_name_reg    <= (cmd.emit_status == ST_REC) ?
                               64'(best_reg[RW-1:16]) : 64'd0;
            out_year_reg    <= (cmd.emit_status == ST_REC) ? best_reg[15:1] : 15'd0;
            out_male_reg    <= (cmd.emit_status == ST_REC) && best_reg[0];
            out_last_reg    <= (cmd.emit_status == ST_REC) ? stat.list_last : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            kept_reg      <= '0;
            removed_reg   <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            rdv_reg       <= 1'b0;
            first_reg     <= 1'b1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rdv_reg <= cmd.rd_issue;
            if (cmd.capture) begin
                kept_reg    <= '0;
                removed_reg <= '0;
                k_reg       <= '0;
                first_reg   <= 1'b1;
            end
            if (cmd.scan_start) begin
                j_reg     <= '0;
                found_reg <= 1'b0;
            end else if (cmd.rd_issue) begin
                j_reg <= j_reg + 1'b1;
            end
            if (rdv_reg && !is_list) begin
                if (match) removed_reg <= removed_reg + 1'b1;
                else       kept_reg    <= kept_reg + 1'b1;
            end
            if (rdv_reg && is_list && above && better) found_reg <= 1'b1;
            if (cmd.list_step) begin
                first_reg <= 1'b0;
                k_reg     <= k_reg + 1'b1;
            end
            if (cmd.add_wr)     count_reg <= count_reg + 1'b1;
            if (cmd.del_commit) count_reg <= kept_reg;
            if (cmd.emit)          out_valid_reg <= 1'b1;
            else if (m_tready)     out_valid_reg <= 1'b0;
        end
    end

    assign stat.add_ok     = (7'(count_reg) < capacity) && (count_reg < CW'(MAX_RECORDS));
    assign stat.count_zero = (count_reg == '0);
    assign stat.rd_done    = (CW'(j_reg) == count_reg - 1'b1);
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.list_last  = (k_reg + 1'b1 == count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_male_reg, out_year_reg, out_name_reg, out_removed_reg};

endmodule

### rtl/record_table_sort_delete.sv
// ----------------------------------------------------------------------------
// record_table_sort_delete
// Record table (name, year, sex) with add, delete-by-match and stable
// sorted listing by name or by year.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | content
//  s_       | in  | s_tvalid/s_tready  | one action item
//  m_       | out | m_tvalid/m_tready  | result items, m_tlast on the final one
//  APB      | in  | psel/penable       | capacity register at 0x0
//
//  Delete reads one record per cycle through the single memory read port.
//  List: n results, each found by a full scan of the n records.
//  Reset (aresetn low, synchronous) empties the table and sets capacity 64;
//  the memory itself is not cleared.
//  One action is worked at a time; a pending result stalls the sequencer
//  until m_tready, while the output register still holds the previous item.
// ----------------------------------------------------------------------------
module record_table_sort_delete import rtsd_pkg::*; #(
    parameter int MAX_RECORDS = 64,
    parameter int NAME_BITS   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // name_key[63:0], year[79:64], sex_char[87:80]
    input  logic [2:0]  s_tuser,   // action
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // removed_count[6:0], rec_name[70:7],
                                   // rec_year[85:71], rec_male[86], zero[87]
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    logic [6:0] capacity_reg;
    rtsd_cmd_t  cmd;
    rtsd_stat_t stat;

    // capacity register; writes elsewhere are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
            capacity_reg <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {25'd0, capacity_reg} : 32'd0;

    rtsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtsd_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .NAME_BITS   (NAME_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_action (s_tuser),
        .in_name   (s_tdata[NAME_BITS-1:0]),
        .in_year   (s_tdata[79:64]),
        .in_sex    (s_tdata[87:80]),
        .capacity  (capacity_reg),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/rtsd_check.sv
// ----------------------------------------------------------------------------
// rtsd_check
// Port-level checks on the result channel of the record table.
// ----------------------------------------------------------------------------
module rtsd_check import rtsd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_ADDED || m_tuser == ST_FULL ||
                     m_tuser == ST_COUNT || m_tuser == ST_REC || m_tuser == ST_EMPTY)
        else $error("bad status");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_REC |-> m_tlast)
        else $error("non-record result without last");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_REC |-> m_tdata[87:7] == '0)
        else $error("record fields set on non-record result");

endmodule

bind record_table_sort_delete rtsd_check u_rtsd_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the record table: a scoreboard keeps its own table
// and predicts every result item of add, delete and sorted listing; random
// idling on both streams, a long receiver hold-off and capacity changes.
// ----------------------------------------------------------------------------
class table_scoreboard;
    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  removed;
        logic [63:0] name;
        logic [14:0] year;
        logic        male;
        logic        last;
    } result_t;

    logic [63:0] names[64];
    logic [14:0] years[64];
    logic        males[64];
    int          count;
    int          capacity;
    result_t     pending[$];
    int          errors;

    function new();
        count = 0;
        capacity = 64;
        errors = 0;
    endfunction

    function void report(string what);
        $display("tb: mismatch: %s", what);
        errors++;
    endfunction

    function automatic bit hit(logic [2:0] act, int i, logic [63:0] key,
                               logic signed [15:0] yr, logic [7:0] sc);
        if (act == rtsd_pkg::ACT_DEL_NAME) return names[i] == key;
        if (act == rtsd_pkg::ACT_DEL_YEAR) return yr >= 0 && {1'b0, years[i]} == yr;
        if (sc == rtsd_pkg::CHAR_M) return males[i];
        if (sc == rtsd_pkg::CHAR_F) return !males[i];
        return 0;
    endfunction

    // note one accepted input item and queue the results it causes
    function void note_item(logic [2:0] act, logic [63:0] key,
                            logic signed [15:0] yr, logic [7:0] sc);
        result_t r;
        int cap, kept, gone, t;
        int ord[64];
        bit by_year, lt;
        r = '0;
        r.last = 1;
        cap = capacity > 64 ? 64 : capacity;
        if (act == rtsd_pkg::ACT_ADD) begin
            if (count < cap) begin
                names[count] = key;
                years[count] = yr < 0 ? 15'd0 : yr[14:0];
                males[count] = sc == rtsd_pkg::CHAR_M;
                count++;
                r.status = rtsd_pkg::ST_ADDED;
            end else begin
                r.status = rtsd_pkg::ST_FULL;
            end
            pending.push_back(r);
        end else if (act <= rtsd_pkg::ACT_DEL_SEX) begin
            kept = 0;
            gone = 0;
            for (int i = 0; i < count; i++) begin
                if (hit(act, i, key, yr, sc)) gone++;
                else begin
                    names[kept] = names[i];
                    years[kept] = years[i];
                    males[kept] = males[i];
                    kept++;
                end
            end
            count = kept;
            r.status = rtsd_pkg::ST_COUNT;
            r.removed = 7'(gone);
            pending.push_back(r);
        end else if (act <= rtsd_pkg::ACT_LIST_YEAR) begin
            by_year = act == rtsd_pkg::ACT_LIST_YEAR;
            if (count == 0) begin
                r.status = rtsd_pkg::ST_EMPTY;
                pending.push_back(r);
                return;
            end
            // stable insertion sort of indexes
            for (int i = 0; i < count; i++) begin
                ord[i] = i;
                for (int j = i; j > 0; j--) begin
                    lt = by_year ? years[ord[j]] < years[ord[j-1]]
                                 : names[ord[j]] < names[ord[j-1]];
                    if (!lt) break;
                    t = ord[j];
                    ord[j] = ord[j-1];
                    ord[j-1] = t;
                end
            end
            for (int i = 0; i < count; i++) begin
                r.status = rtsd_pkg::ST_REC;
                r.name = names[ord[i]];
                r.year = years[ord[i]];
                r.male = males[ord[i]];
                r.last = i + 1 == count;
                pending.push_back(r);
            end
        end
    endfunction

    function void check_result(logic [2:0] st, logic [87:0] d, logic lst);
        result_t e;
        if (pending.size() == 0) begin
            report($sformatf("unexpected item status %0d", st));
            return;
        end
        e = pending.pop_front();
        if (st !== e.status) report($sformatf("status %0d want %0d", st, e.status));
        if (d[6:0] !== e.removed)
            report($sformatf("removed %0d want %0d", d[6:0], e.removed));
        if (d[70:7] !== e.name) report($sformatf("name %h want %h", d[70:7], e.name));
        if (d[85:71] !== e.year) report($sformatf("year %0d want %0d", d[85:71], e.year));
        if (d[86] !== e.male) report($sformatf("male %b want %b", d[86], e.male));
        if (d[87] !== 1'b0) report("pad bit set");
        if (lst !== e.last) report($sformatf("last %b want %b", lst, e.last));
    endfunction
endclass

module tb;
    import rtsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;   // name_key[63:0], year[79:64], sex_char[87:80]
    logic [2:0]  s_tuser = '0;   // action
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;        // removed[6:0], name[70:7], year[85:71], male[86]
    logic [2:0]  m_tuser;        // status
    logic        m_tlast;

    table_scoreboard sb = new();
    int  hold_off = 0;   // receiver hold-off request, in cycles
    logic [63:0] name_pool[8];

    record_table_sort_delete dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    initial begin
        #200ms;
        $display("tb: errors");
        $finish;
    end

    // short gaps mostly, now and then a long one, sometimes none at all
    function automatic int gap();
        int p;
        p = $urandom_range(99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(3);
        return $urandom_range(40, 10);
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(99) < 70);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= val; penable <= 0;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.capacity = val[6:0];
    endtask

    // s_tvalid stays up after an accept; a send that idles first, or a drain, drops it
    task automatic send(logic [2:0] act, logic [63:0] key, logic [15:0] yr,
                        logic [7:0] sc);
        int g;
        g = gap();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {sc, yr, key};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(act, key, yr, sc);
    endtask

    // wait for all results, then past the latency of a silent action
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_random(int pct_add);
        logic [2:0] act;
        logic [7:0] sc;
        logic [15:0] yr;
        logic [63:0] key;
        int p;
        p = $urandom_range(99);
        if (p < pct_add) act = ACT_ADD;
        else if (p < pct_add + 6) act = ACT_LIST_NAME;
        else if (p < pct_add + 12) act = ACT_LIST_YEAR;
        else if (p < 96) act = 3'($urandom_range(3, 1));
        else act = 3'($urandom_range(7, 6));
        key = ($urandom_range(3) == 0) ? {$urandom, $urandom} : name_pool[$urandom_range(7)];
        yr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(1990 + $urandom_range(5));
        case ($urandom_range(3))
            0: sc = CHAR_M;
            1: sc = CHAR_F;
            2: sc = 8'($urandom);
            default: sc = CHAR_M;
        endcase
        send(act, key, yr, sc);
    endtask

    initial begin
        foreach (name_pool[i]) name_pool[i] = {$urandom, $urandom};
        name_pool[0] = '0;
        name_pool[1] = '1;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: empty lists, extremes, clamping, every delete kind
        send(ACT_LIST_NAME, '0, '0, '0);
        send(ACT_LIST_YEAR, '0, '0, '0);
        send(ACT_ADD, '1, 16'h7FFF, CHAR_M);
        send(ACT_ADD, '0, 16'h8000, 8'hFF);          // negative year -> 0, female
        send(ACT_ADD, 64'h4142000000000000, 16'd1990, CHAR_F);
        send(ACT_ADD, 64'h4142000000000000, 16'd1990, CHAR_M); // tie for stability
        send(ACT_ADD, 64'h0000000000000001, 16'd0, 8'h00);
        send(ACT_LIST_NAME, '0, '0, '0);
        send(ACT_LIST_YEAR, '0, '0, '0);
        send(ACT_DEL_YEAR, '0, 16'hFFFF, '0);        // negative year matches none
        send(ACT_DEL_SEX, '0, '0, 8'h41);            // other char matches none
        send(ACT_DEL_SEX, '0, '0, CHAR_M);
        send(3'd6, '0, '0, '0);
        send(3'd7, '1, '1, '1);
        send(ACT_DEL_NAME, 64'h4142000000000000, '0, '0);
        send(ACT_DEL_YEAR, '0, 16'd0, '0);
        send(ACT_DEL_SEX, '0, '0, CHAR_F);
        send(ACT_LIST_YEAR, '0, '0, '0);
        drain();

        // capacity 1 and 0, then below the current count
        apb_write(ADDR_CAPACITY, 32'd1);
        send(ACT_ADD, 64'h55, 16'd5, CHAR_M);
        send(ACT_ADD, 64'h56, 16'd6, CHAR_M);
        drain();
        apb_write(ADDR_CAPACITY, 32'd0);
        send(ACT_ADD, 64'h57, 16'd7, CHAR_F);
        drain();
        apb_write(ADDR_CAPACITY, 32'd127);           // saturates at 64

        // fill to the maximum, with a long hold-off while listing
        for (int i = 0; i < 66; i++) send_random(100);
        hold_off = 300;
        send(ACT_LIST_YEAR, '0, '0, '0);
        send(ACT_LIST_NAME, '0, '0, '0);
        send(ACT_ADD, '0, '0, '0);
        drain();
        apb_write(ADDR_CAPACITY, 32'd3);
        send(ACT_ADD, '0, '0, '0);
        send(ACT_DEL_SEX, '0, '0, CHAR_M);
        drain();
        apb_write(ADDR_CAPACITY, 32'd12);

        // random phase, small table
        for (int i = 0; i < 10; i++) send_random(50);
        drain();
        apb_write(ADDR_CAPACITY, 32'd64);
        for (int i = 0; i < 5; i++) send_random(60);
        drain();

        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
